// File: hw/rtl/mts_pkg.sv
// Shared constants, codes and control types for the min tracking stack.
package mts_pkg;

	// Fixed field widths.
	localparam int DATA_W = 32;
	localparam int FILL_W = 11;
	localparam int STAT_W = 2;

	// Default number of stack entries.
	localparam int STACK_DEPTH_DEF = 1024;

	// Values reported for an empty stack.
	localparam logic signed [DATA_W-1:0] EMPTY_TOP = -32'sd1;
	localparam logic signed [DATA_W-1:0] EMPTY_MIN = 32'sh7FFF_FFFF;

	// Action codes of an input item.
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// Status codes of a result item.
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic push;       // push the item's value
		logic pop_empty;  // pop the last entry, stack becomes empty
		logic pop_read;   // pop and fetch the new top from the stores
		logic load;       // take the fetched entry as the new top
	} cmd_t;

	// Fill level flags from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic one;
		logic full;
	} flags_t;

endpackage

// File: hw/rtl/min_tracking_stack_unit.sv
// Min tracking stack: a bounded LIFO of signed words that reports its minimum.
// A push, an empty or full case, or a pop down to empty shows its result in the
// cycle after acceptance; a pop that leaves entries first reads the entry and minimum
// stores into registers, then loads them as the new top in the load state, with busy high.
// Throughput: one item per cycle while not busy; the receiver cannot stall.
// Reset clears the fill count, state and strobe; the stores need no clearing.
module min_tracking_stack_unit #(
	parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 action,
	input  logic signed [mts_pkg::DATA_W-1:0]    value,
	output logic                                 done,
	output logic signed [mts_pkg::DATA_W-1:0]    top_value,
	output logic signed [mts_pkg::DATA_W-1:0]    min_value,
	output logic [mts_pkg::FILL_W-1:0]           fill_count,
	output logic [mts_pkg::STAT_W-1:0]           status
);

	mts_pkg::cmd_t   cmd;
	mts_pkg::flags_t flags;

	// Controller.
	mts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.flags  (flags),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.status (status)
	);

	// Datapath.
	mts_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (value),
		.flags      (flags),
		.top_value  (top_value),
		.min_value  (min_value),
		.fill_count (fill_count)
	);

endmodule

// File: hw/rtl/mts_ctrl.sv
// Controller state machine: accepts items, sequences pops and strobes results.
module mts_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          action,
	input  mts_pkg::flags_t               flags,
	output mts_pkg::cmd_t                 cmd,
	output logic                          busy,
	output logic                          done,
	output logic [mts_pkg::STAT_W-1:0]    status
);

	typedef enum logic {
		ST_IDLE,
		ST_LOAD
	} state_t;

	state_t                       state_q;
	logic                         done_q;
	logic [mts_pkg::STAT_W-1:0]   status_q;
	logic                         accept;

	// An item is taken only while no fetch is in flight.
	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Decode the accepted item into datapath commands.
	always_comb begin
		cmd.push      = accept && (action == mts_pkg::ACT_PUSH) && !flags.full;
		cmd.pop_empty = accept && (action == mts_pkg::ACT_POP) && flags.one;
		cmd.pop_read  = accept && (action == mts_pkg::ACT_POP) && !flags.empty && !flags.one;
		cmd.load      = (state_q == ST_LOAD);
	end

	// State and registered result strobe and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			status_q <= mts_pkg::STAT_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action == mts_pkg::ACT_PUSH) begin
							status_q <= flags.full ? mts_pkg::STAT_OVERFLOW : mts_pkg::STAT_OK;
						end else begin
							status_q <= flags.empty ? mts_pkg::STAT_UNDERFLOW : mts_pkg::STAT_OK;
						end
						if (cmd.pop_read) begin
							state_q <= ST_LOAD;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign status = status_q;

endmodule

// File: hw/rtl/mts_dp.sv
// Datapath: entry and running minimum stores, cached top, fill count.
module mts_dp #(
	parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mts_pkg::cmd_t                        cmd,
	input  logic signed [mts_pkg::DATA_W-1:0]    value,
	output mts_pkg::flags_t                      flags,
	output logic signed [mts_pkg::DATA_W-1:0]    top_value,
	output logic signed [mts_pkg::DATA_W-1:0]    min_value,
	output logic [mts_pkg::FILL_W-1:0]           fill_count
);

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	logic signed [mts_pkg::DATA_W-1:0] entry_mem [STACK_DEPTH];
	logic signed [mts_pkg::DATA_W-1:0] rmin_mem  [STACK_DEPTH];

	logic [CNT_W-1:0]                  cnt_q;
	logic signed [mts_pkg::DATA_W-1:0] top_q;
	logic signed [mts_pkg::DATA_W-1:0] min_q;
	logic signed [mts_pkg::DATA_W-1:0] ent_rd_q;
	logic signed [mts_pkg::DATA_W-1:0] min_rd_q;
	logic signed [mts_pkg::DATA_W-1:0] push_min;
	logic [CNT_W-1:0]                  rd_cnt;
	logic [ADDR_W-1:0]                 wr_addr;
	logic [ADDR_W-1:0]                 rd_addr;

	// Fill level flags.
	assign flags.empty = (cnt_q == '0);
	assign flags.one   = (cnt_q == CNT_W'(1));
	assign flags.full  = (cnt_q == CNT_W'(STACK_DEPTH));

	// Running minimum of the pushed value and everything below it.
	assign push_min = (!flags.empty && (min_q < value)) ? min_q : value;

	// A push writes at the fill count; a pop fetches the entry under the top.
	assign wr_addr = cnt_q[ADDR_W-1:0];
	assign rd_cnt  = cnt_q - CNT_W'(2);
	assign rd_addr = rd_cnt[ADDR_W-1:0];

	// Store write and registered read.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			entry_mem[wr_addr] <= value;
			rmin_mem[wr_addr]  <= push_min;
		end
		if (cmd.pop_read) begin
			ent_rd_q <= entry_mem[rd_addr];
			min_rd_q <= rmin_mem[rd_addr];
		end
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.push) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.pop_empty || cmd.pop_read) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Cached top entry and its running minimum.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= value;
			min_q <= push_min;
		end else if (cmd.pop_empty) begin
			top_q <= mts_pkg::EMPTY_TOP;
			min_q <= mts_pkg::EMPTY_MIN;
		end else if (cmd.load) begin
			top_q <= ent_rd_q;
			min_q <= min_rd_q;
		end
	end

	// An empty stack always reports the empty values.
	assign top_value  = flags.empty ? mts_pkg::EMPTY_TOP : top_q;
	assign min_value  = flags.empty ? mts_pkg::EMPTY_MIN : min_q;
	assign fill_count = mts_pkg::FILL_W'(cnt_q);

endmodule

// File: dv/tb_min_tracking_stack_unit.sv
// Testbench for the min tracking stack: random push and pop items checked against a predictor.

// One result item as the predictor expects it.
typedef struct {
	logic signed [mts_pkg::DATA_W-1:0] top;
	logic signed [mts_pkg::DATA_W-1:0] low;
	logic [mts_pkg::FILL_W-1:0]        fill;
	logic [mts_pkg::STAT_W-1:0]        stat;
} stack_view_t;

// Tracks the stack contents and running minima, and checks each result item in order.
class min_stack_tracker;
	logic signed [mts_pkg::DATA_W-1:0] entries[];
	logic signed [mts_pkg::DATA_W-1:0] run_mins[];
	int unsigned depth_limit;
	int unsigned level;
	int errors;
	stack_view_t expected_views[$];

	function new(int unsigned depth);
		depth_limit = depth;
		entries = new[depth];
		run_mins = new[depth];
		level = 0;
		errors = 0;
	endfunction

	function int pending();
		return expected_views.size();
	endfunction

	// Applies one accepted item to the predicted stack and queues the result it causes.
	function void note_item(logic act, logic signed [mts_pkg::DATA_W-1:0] val);
		stack_view_t view;
		logic signed [mts_pkg::DATA_W-1:0] low;
		view.stat = mts_pkg::STAT_OK;
		if (act == mts_pkg::ACT_PUSH) begin
			if (level >= depth_limit) begin
				view.stat = mts_pkg::STAT_OVERFLOW;
			end else begin
				low = val;
				if (level > 0 && run_mins[level-1] < val)
					low = run_mins[level-1];
				entries[level] = val;
				run_mins[level] = low;
				level++;
			end
		end else if (level == 0) begin
			view.stat = mts_pkg::STAT_UNDERFLOW;
		end else begin
			level--;
		end
		if (level > 0) begin
			view.top = entries[level-1];
			view.low = run_mins[level-1];
		end else begin
			view.top = mts_pkg::EMPTY_TOP;
			view.low = mts_pkg::EMPTY_MIN;
		end
		view.fill = level[mts_pkg::FILL_W-1:0];
		expected_views.push_back(view);
	endfunction

	function void check_field(string tag, logic signed [mts_pkg::DATA_W:0] exp_val,
			logic signed [mts_pkg::DATA_W:0] got_val);
		if (got_val !== exp_val) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, exp_val, got_val);
		end
	endfunction

	// Compares one result item with the oldest expectation.
	function void check_result(logic signed [mts_pkg::DATA_W-1:0] top,
			logic signed [mts_pkg::DATA_W-1:0] low, logic [mts_pkg::FILL_W-1:0] fill,
			logic [mts_pkg::STAT_W-1:0] stat);
		stack_view_t view;
		if (expected_views.size() == 0) begin
			errors++;
			$display("%0t: result with no item pending, expected none, actual top %0d fill %0d",
				$time, top, fill);
			return;
		end
		view = expected_views.pop_front();
		check_field("top_value", view.top, top);
		check_field("min_value", view.low, low);
		check_field("fill_count", view.fill, fill);
		check_field("status", view.stat, stat);
	endfunction
endclass

module tb_min_tracking_stack_unit;
	import mts_pkg::*;

	localparam int DEPTH = STACK_DEPTH_DEF;
	localparam int ITEM_TARGET = 1950;
	localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic action = ACT_PUSH;
	logic signed [DATA_W-1:0] value = '0;
	logic done;
	logic signed [DATA_W-1:0] top_value;
	logic signed [DATA_W-1:0] min_value;
	logic [FILL_W-1:0] fill_count;
	logic [STAT_W-1:0] status;

	min_stack_tracker tracker = new(DEPTH);
	int items_sent = 0;
	bit no_idle = 1'b0;

	min_tracking_stack_unit #(.STACK_DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .value(value), .done(done),
		.top_value(top_value), .min_value(min_value),
		.fill_count(fill_count), .status(status)
	);

	always #5 clk = ~clk;

	// Every strobed result item is checked at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			tracker.check_result(top_value, min_value, fill_count, status);
	end

	function automatic int draw_gap();
		if (no_idle)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	// Mix of extremes, ties, a falling trend and full random words.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return $signed(DATA_W'($urandom_range(0, 2))) - 1;
			3, 4: return $signed(DATA_W'($urandom_range(0, 200))) - 100;
			5, 6: return 4000 - 8 * $signed(DATA_W'(tracker.level))
				+ $signed(DATA_W'($urandom_range(0, 15)));
			default: return $signed($urandom);
		endcase
	endfunction

	// Presents one item after an idle gap and returns at the edge that accepts it.
	task automatic send_item(logic act, logic signed [DATA_W-1:0] val, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		value <= val;
		do @(posedge clk); while (busy !== 1'b0);
		tracker.note_item(act, val);
		items_sent++;
	endtask

	task automatic send_random(int pop_pct);
		if ($urandom_range(1, 100) <= pop_pct)
			send_item(ACT_POP, $signed($urandom), draw_gap());
		else
			send_item(ACT_PUSH, pick_value(), draw_gap());
	endtask

	task automatic wait_drained();
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pops on empty, extremes, ties and a drain back to empty.
		send_item(ACT_POP, $signed($urandom), draw_gap());
		send_item(ACT_POP, WORD_MIN, 0);
		send_item(ACT_PUSH, WORD_MAX, 0);
		send_item(ACT_PUSH, 0, draw_gap());
		send_item(ACT_PUSH, WORD_MAX, 0);
		send_item(ACT_PUSH, -1, draw_gap());
		send_item(ACT_PUSH, WORD_MIN, 0);
		send_item(ACT_PUSH, WORD_MIN, 0);
		send_item(ACT_PUSH, 32'sh5555_5555, draw_gap());
		send_item(ACT_PUSH, 32'shAAAA_AAAA, 0);
		repeat (10) send_item(ACT_POP, WORD_MAX, draw_gap());
		send_item(ACT_PUSH, -1, 0);
		send_item(ACT_POP, 0, 0);
		send_item(ACT_PUSH, 1, draw_gap());
		send_item(ACT_PUSH, 1, 0);

		// Balanced random walk around empty, in stretches with and without idling.
		while (items_sent < 330) begin
			no_idle = ($urandom_range(0, 3) == 0);
			repeat (50) send_random(50);
		end

		// Sender holds off until every result is back before filling the stack.
		start <= 1'b0;
		no_idle = 1'b0;
		wait_drained();

		// Fill to capacity, mostly back to back, then work around the full mark.
		while (tracker.level < DEPTH) begin
			no_idle = ($urandom_range(0, 7) != 0);
			send_item(ACT_PUSH, pick_value(), draw_gap());
		end
		no_idle = 1'b0;
		repeat (4) send_item(ACT_PUSH, pick_value(), draw_gap());
		repeat (12) send_random(30);
		while (tracker.level < DEPTH) send_item(ACT_PUSH, pick_value(), draw_gap());
		send_item(ACT_PUSH, WORD_MIN, 0);

		// Pop-heavy drain for the rest of the run.
		while (items_sent < ITEM_TARGET) begin
			no_idle = ($urandom_range(0, 2) == 0);
			repeat (40) send_random(80);
		end
		start <= 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("min_tracking_stack_unit verification clean");
		else
			$display("min_tracking_stack_unit verification failed");
		$finish;
	end

	// Hang guard, several times the slowest legal run.
	initial begin
		#5000000;
		$display("min_tracking_stack_unit verification failed");
		$finish;
	end

endmodule
